[src/fcr_pkg.sv]
`timescale 1ns / 1ps

package fcr_pkg;

	// Field widths of the stream words.
	localparam int COORD_W = 13;
	localparam int RAD_W   = 11;
	localparam int PIX_W   = 14;
	localparam int DIM_W   = 12;
	localparam int COLOR_W = 16;
	localparam int ADDR_W  = 23;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR    = 2'd2;

	localparam logic [DIM_W-1:0]   RESET_WIDTH  = 12'd1280;
	localparam logic [DIM_W-1:0]   RESET_HEIGHT = 12'd720;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 16'd0;

	// Command and result kinds.
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_STEP   = 1'b1;
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_IDLE  = 1'b1;

	localparam int DEF_MAX_RADIUS = 2047;
	localparam int QUEUE_DEPTH    = 4;

	// Index of the last point emitted for one step.
	localparam logic [2:0] LAST_POINT = 3'd7;

	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [COLOR_W-1:0] color;
	} cfg_t;

endpackage

[src/filled_circle_rasterizer.sv]
`timescale 1ns / 1ps

// Filled-circle rasterizer. A start word (tuser 0) loads a centre and a radius
// and produces no output; a circle that lies wholly off the screen is dropped.
// Each step word (tuser 1) produces the eight mirrored points of the current
// span position as eight output words, one per cycle while the output is not
// stalled, with tlast on the final point of the circle; a step with no circle
// active produces one idle word. The input side accepts one word per cycle
// while the four-entry job queue has room, so it can take new steps before
// the back end is through with earlier ones. The first word of a step passes
// through the job queue and the coordinate, bounds and output registers of the
// back end. Points off the screen carry on_screen 0 and address 0. Configuration
// must be written by the user only while no results are pending; the block
// itself does not enforce this. cfg_ready is always high.
module filled_circle_rasterizer
	import fcr_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration writes.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Command stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// center_x [12:0], center_y [25:13], radius [36:26], zero [39:37]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd [0]
	input  logic                   s_tuser,
	// Pixel stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// pixel_x [13:0], pixel_y [27:14], on_screen [28], byte_address [51:29],
	// pixel_color [67:52], zero [71:68]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// kind [0]
	output logic                   m_tuser,
	output logic                   m_tlast
);

	localparam int RW    = $clog2(MAX_RADIUS + 2);
	localparam int JOB_W = 2 + 2 * COORD_W + 2 * RW;

	cfg_t cfg_q;

	logic                      q_full;
	logic                      push;
	logic                      pop;
	logic                      head_valid;
	logic [JOB_W-1:0]          push_data;
	logic [JOB_W-1:0]          head_data;

	logic                      f_idle;
	logic signed [COORD_W-1:0] f_cx;
	logic signed [COORD_W-1:0] f_cy;
	logic [RW-1:0]             f_a;
	logic [RW-1:0]             f_b;
	logic                      f_done;

	logic                      h_idle;
	logic signed [COORD_W-1:0] h_cx;
	logic signed [COORD_W-1:0] h_cy;
	logic [RW-1:0]             h_a;
	logic [RW-1:0]             h_b;
	logic                      h_done;

	logic                      o_kind;
	logic signed [PIX_W-1:0]   o_px;
	logic signed [PIX_W-1:0]   o_py;
	logic                      o_on;
	logic [ADDR_W-1:0]         o_addr;
	logic [COLOR_W-1:0]        o_color;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RESET_WIDTH;
			cfg_q.height <= RESET_HEIGHT;
			cfg_q.color  <= RESET_COLOR;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH: begin
					cfg_q.width <= cfg_data[DIM_W-1:0];
				end
				CFG_SCREEN_HEIGHT: begin
					cfg_q.height <= cfg_data[DIM_W-1:0];
				end
				CFG_DRAW_COLOR: begin
					cfg_q.color <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	fcr_front #(
		.MAX_RADIUS (MAX_RADIUS),
		.RW         (RW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_cx     (s_tdata[COORD_W-1:0]),
		.in_cy     (s_tdata[2*COORD_W-1:COORD_W]),
		.in_radius (s_tdata[2*COORD_W+RAD_W-1:2*COORD_W]),
		.q_full    (q_full),
		.job_push  (push),
		.job_idle  (f_idle),
		.job_cx    (f_cx),
		.job_cy    (f_cy),
		.job_a     (f_a),
		.job_b     (f_b),
		.job_done  (f_done)
	);

	assign push_data = {f_idle, f_done, f_cx, f_cy, f_a, f_b};

	fcr_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign {h_idle, h_done, h_cx, h_cy, h_a, h_b} = head_data;

	fcr_back #(
		.MAX_RADIUS (MAX_RADIUS),
		.RW         (RW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (head_valid),
		.job_idle  (h_idle),
		.job_cx    (h_cx),
		.job_cy    (h_cy),
		.job_a     (h_a),
		.job_b     (h_b),
		.job_done  (h_done),
		.job_pop   (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (o_kind),
		.out_px    (o_px),
		.out_py    (o_py),
		.out_on    (o_on),
		.out_addr  (o_addr),
		.out_color (o_color),
		.out_last  (m_tlast)
	);

	// Output word packing.
	assign m_tuser = o_kind;
	assign m_tdata = {4'b0, o_color, o_addr, o_on, o_py, o_px};

endmodule

[src/fcr_queue.sv]
`timescale 1ns / 1ps

module fcr_queue
	import fcr_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/fcr_front.sv]
`timescale 1ns / 1ps

module fcr_front
	import fcr_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int RW = $clog2(MAX_RADIUS + 2)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_cmd,
	input  logic signed [COORD_W-1:0] in_cx,
	input  logic signed [COORD_W-1:0] in_cy,
	input  logic [RAD_W-1:0]          in_radius,
	input  logic                      q_full,
	output logic                      job_push,
	output logic                      job_idle,
	output logic signed [COORD_W-1:0] job_cx,
	output logic signed [COORD_W-1:0] job_cy,
	output logic [RW-1:0]             job_a,
	output logic [RW-1:0]             job_b,
	output logic                      job_done
);

	localparam int DW = RW + 4;
	localparam int SW = COORD_W + 2;
	localparam logic [RAD_W:0] MAX_R = (RAD_W + 1)'(MAX_RADIUS);

	logic                      active_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [RW-1:0]             x_q;
	logic [RW-1:0]             y_q;
	logic [RW-1:0]             span_q;
	logic signed [DW-1:0]      d_q;

	logic                      accept;
	logic [RW-1:0]             r_sat;
	logic signed [SW-1:0]      cx_w;
	logic signed [SW-1:0]      cy_w;
	logic signed [SW-1:0]      r_w;
	logic signed [SW-1:0]      wid_w;
	logic signed [SW-1:0]      hgt_w;
	logic                      dropped;
	logic [RW-1:0]             span_inc;
	logic [RW-1:0]             x_n;
	logic [RW-1:0]             y_n;
	logic [RW-1:0]             span_n;
	logic signed [DW-1:0]      d_n;
	logic signed [DW-1:0]      x_d;
	logic signed [DW-1:0]      y_d;
	logic                      done;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// Start: saturate the radius and test whether the circle misses the screen.
	always_comb begin
		r_sat   = ({1'b0, in_radius} > MAX_R) ? RW'(MAX_RADIUS) : RW'(in_radius);
		cx_w    = {{(SW - COORD_W){in_cx[COORD_W-1]}}, in_cx};
		cy_w    = {{(SW - COORD_W){in_cy[COORD_W-1]}}, in_cy};
		r_w     = $signed(SW'(r_sat));
		wid_w   = $signed(SW'(cfg.width));
		hgt_w   = $signed(SW'(cfg.height));
		dropped = (cx_w + r_w < 0) || (cx_w - r_w >= wid_w) ||
		          (cy_w + r_w < 0) || (cy_w - r_w >= hgt_w);
	end

	// Step: advance the span, and the midpoint walk when the span passes y.
	always_comb begin
		span_inc = span_q + 1'b1;
		x_d      = $signed(DW'(x_q));
		y_d      = $signed(DW'(y_q));
		x_n      = x_q;
		y_n      = y_q;
		d_n      = d_q;
		span_n   = span_inc;
		if (span_inc > y_q) begin
			if (d_q < 0) begin
				d_n = d_q + (x_d <<< 2) + DW'(6);
			end else begin
				d_n = d_q + ((x_d - y_d) <<< 2) + DW'(10);
				y_n = y_q - 1'b1;
			end
			x_n    = x_q + 1'b1;
			span_n = x_q + 1'b1;
		end
		// A zero radius walks y below zero, which also ends the circle.
		done = (x_n > y_n) || ((y_q == '0) && (y_n != '0));
	end

	// Job handed to the back end for every step command.
	assign job_push = accept && (in_cmd == CMD_STEP);
	assign job_idle = !active_q;
	assign job_cx   = cx_q;
	assign job_cy   = cy_q;
	assign job_a    = x_q;
	assign job_b    = span_q;
	assign job_done = done;

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			span_q   <= '0;
			d_q      <= '0;
		end else if (accept) begin
			if (in_cmd == CMD_START) begin
				active_q <= !dropped;
				if (!dropped) begin
					cx_q   <= in_cx;
					cy_q   <= in_cy;
					x_q    <= '0;
					y_q    <= r_sat;
					span_q <= '0;
					d_q    <= $signed(DW'(3)) - $signed(DW'({r_sat, 1'b0}));
				end
			end else if (active_q) begin
				x_q    <= x_n;
				y_q    <= y_n;
				span_q <= span_n;
				d_q    <= d_n;
				if (done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

[src/fcr_back.sv]
`timescale 1ns / 1ps

module fcr_back
	import fcr_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int RW = $clog2(MAX_RADIUS + 2)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      job_valid,
	input  logic                      job_idle,
	input  logic signed [COORD_W-1:0] job_cx,
	input  logic signed [COORD_W-1:0] job_cy,
	input  logic [RW-1:0]             job_a,
	input  logic [RW-1:0]             job_b,
	input  logic                      job_done,
	output logic                      job_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_kind,
	output logic signed [PIX_W-1:0]   out_px,
	output logic signed [PIX_W-1:0]   out_py,
	output logic                      out_on,
	output logic [ADDR_W-1:0]         out_addr,
	output logic [COLOR_W-1:0]        out_color,
	output logic                      out_last
);

	localparam int PROD_W = 2 * DIM_W;

	logic                    stall;
	logic                    issue;
	logic [2:0]              k_q;
	logic [RW-1:0]           off_x;
	logic [RW-1:0]           off_y;
	logic signed [PIX_W-1:0] cx_w;
	logic signed [PIX_W-1:0] cy_w;
	logic signed [PIX_W-1:0] px_c;
	logic signed [PIX_W-1:0] py_c;

	// Stage 1: point coordinates.
	logic                    v_s1;
	logic                    kind_s1;
	logic signed [PIX_W-1:0] px_s1;
	logic signed [PIX_W-1:0] py_s1;
	logic [COLOR_W-1:0]      color_s1;
	logic                    last_s1;

	// Stage 2: bounds test and row offset product.
	logic                    v_s2;
	logic                    kind_s2;
	logic signed [PIX_W-1:0] px_s2;
	logic signed [PIX_W-1:0] py_s2;
	logic                    on_s2;
	logic [PROD_W-1:0]       prod_s2;
	logic [COLOR_W-1:0]      color_s2;
	logic                    last_s2;
	logic                    on_c;
	logic [PROD_W:0]         sum_c;

	// Output register.
	logic                    v_q;
	logic                    kind_q;
	logic signed [PIX_W-1:0] px_q;
	logic signed [PIX_W-1:0] py_q;
	logic                    on_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [COLOR_W-1:0]      color_q;
	logic                    last_q;

	assign stall   = v_q && !out_ready;
	assign issue   = job_valid && !stall;
	assign job_pop = issue && (job_idle || (k_q == LAST_POINT));

	// Point index within the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= job_pop ? '0 : k_q + 1'b1;
		end
	end

	// Bit 2 swaps the offsets, bit 0 mirrors the column, bit 1 mirrors the row.
	always_comb begin
		off_x = k_q[2] ? job_b : job_a;
		off_y = k_q[2] ? job_a : job_b;
		cx_w  = {{(PIX_W - COORD_W){job_cx[COORD_W-1]}}, job_cx};
		cy_w  = {{(PIX_W - COORD_W){job_cy[COORD_W-1]}}, job_cy};
		px_c  = k_q[0] ? cx_w - $signed(PIX_W'(off_x)) : cx_w + $signed(PIX_W'(off_x));
		py_c  = k_q[1] ? cy_w - $signed(PIX_W'(off_y)) : cy_w + $signed(PIX_W'(off_y));
	end

	always_comb begin
		on_c = (px_s1 >= 0) && (py_s1 >= 0) &&
		       (px_s1 < $signed(PIX_W'(cfg.width))) &&
		       (py_s1 < $signed(PIX_W'(cfg.height)));
		sum_c = {1'b0, prod_s2} + (PROD_W + 1)'(px_s2[DIM_W-1:0]);
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (!stall) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_q  <= v_s2;
		end
	end

	// Payload of the pipeline; an idle job carries zeros throughout.
	always_ff @(posedge clk) begin
		if (!stall) begin
			kind_s1  <= job_idle ? KIND_IDLE : KIND_PIXEL;
			px_s1    <= job_idle ? '0 : px_c;
			py_s1    <= job_idle ? '0 : py_c;
			color_s1 <= job_idle ? '0 : cfg.color;
			last_s1  <= !job_idle && job_done && (k_q == LAST_POINT);

			kind_s2  <= kind_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			on_s2    <= (kind_s1 == KIND_PIXEL) && on_c;
			prod_s2  <= py_s1[DIM_W-1:0] * cfg.width;
			color_s2 <= color_s1;
			last_s2  <= last_s1;

			kind_q   <= kind_s2;
			px_q     <= px_s2;
			py_q     <= py_s2;
			on_q     <= on_s2;
			addr_q   <= on_s2 ? {sum_c[ADDR_W-2:0], 1'b0} : '0;
			color_q  <= color_s2;
			last_q   <= last_s2;
		end
	end

	assign out_valid = v_q;
	assign out_kind  = kind_q;
	assign out_px    = px_q;
	assign out_py    = py_q;
	assign out_on    = on_q;
	assign out_addr  = addr_q;
	assign out_color = color_q;
	assign out_last  = last_q;

`ifndef SYNTHESIS
	// An idle word carries no point at all.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && kind_q == KIND_IDLE) |->
		(px_q == '0 && py_q == '0 && !on_q && addr_q == '0 && color_q == '0 && !last_q))
		else $error("idle word carries point data");

	// A point off the screen never gets an address.
	a_off_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !on_q) |-> (addr_q == '0))
		else $error("off-screen point has an address");

	// The point index only runs while a pixel job is at the head.
	a_index_job: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != '0) |-> (job_valid && !job_idle))
		else $error("point index runs without a pixel job");

	// The index returns to zero after the eighth point of a job.
	a_index_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && k_q == LAST_POINT) |=> (k_q == '0))
		else $error("point index did not wrap");
`endif

endmodule
